/* src/tte_pkg.sv */
// Package for the tap tempo estimator: field widths, register codes, reset values,
// controller states and the command and status structs between controller and datapath.
// Has no dependencies.
package tte_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned BPM_W      = 10;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned MS_PER_MIN = 60000;

  localparam logic [1:0] REG_RESET_GAP  = 2'd0;
  localparam logic [1:0] REG_TEMPO_LOW  = 2'd1;
  localparam logic [1:0] REG_TEMPO_HIGH = 2'd2;

  localparam logic [GAP_W-1:0] RESET_GAP_INIT  = 16'd2000;
  localparam logic [BPM_W-1:0] TEMPO_LOW_INIT  = 10'd20;
  localparam logic [BPM_W-1:0] TEMPO_HIGH_INIT = 10'd300;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_NEW,
    ST_UPD,
    ST_RD_OLD,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } tte_state_t;

  typedef struct packed {
    logic capture;
    logic rd_new;
    logic upd;
    logic rd_old;
    logic start;
    logic step;
    logic finish;
  } tte_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_done;
    logic out_free;
  } tte_stat_t;

endpackage

/* src/tte_ctrl.sv */
// Controller state machine of the tap tempo estimator.
// Sequences one tap through the datapath. Depends on tte_pkg.
module tte_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               tap_valid,
  output logic               tap_stall,
  input  tte_pkg::tte_stat_t status,
  output tte_pkg::tte_cmd_t  cmd
);
  import tte_pkg::*;

  tte_state_t state;
  tte_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    tap_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        tap_stall   = 1'b0;
        cmd.capture = tap_valid;
        if (tap_valid) begin
          state_next = ST_RD_NEW;
        end
      end
      ST_RD_NEW: begin
        cmd.rd_new = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        cmd.rd_old = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.start = 1'b1;
        if (status.skip) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    tap_valid && !tap_stall |=> tap_stall)
    else $error("controller took a second tap while busy");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DIV) |-> $past(state == ST_PREP))
    else $error("division started without operand setup");

endmodule

/* src/tte_dp.sv */
// Datapath of the tap tempo estimator: tap memory, window bookkeeping,
// restoring divider, clamp and the result register. Depends on tte_pkg.
module tte_dp #(
  parameter int unsigned WINDOW_TAPS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tte_pkg::tte_cmd_t                      cmd,
  output tte_pkg::tte_stat_t                     status,
  input  logic [tte_pkg::TIME_W-1:0]             tap_time_ms,
  input  logic [tte_pkg::GAP_W-1:0]              reset_gap_ms,
  input  logic [tte_pkg::BPM_W-1:0]              tempo_low,
  input  logic [tte_pkg::BPM_W-1:0]              tempo_high,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic                                   tempo_valid,
  output logic [tte_pkg::BPM_W-1:0]              tempo_bpm,
  output logic [$clog2(WINDOW_TAPS+1)-1:0]       taps_held
);
  import tte_pkg::*;

  localparam int unsigned SW    = $clog2(WINDOW_TAPS);
  localparam int unsigned CW    = $clog2(WINDOW_TAPS + 1);
  localparam int unsigned OW    = CW + 1;
  localparam int unsigned NUM_W = 16 + CW;
  localparam int unsigned DVD_W = (NUM_W + 2 > TIME_W + 1) ? NUM_W + 2 : TIME_W + 1;
  localparam int unsigned IW    = $clog2(DVD_W);

  logic [TIME_W-1:0] store [WINDOW_TAPS];
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] rdata;
  logic [SW-1:0]     newest;
  logic [CW-1:0]     count;
  logic [NUM_W-1:0]  num_q;
  logic [DVD_W-1:0]  dq;
  logic [DVD_W-1:0]  dvs;
  logic [DVD_W-1:0]  rem;
  logic [IW-1:0]     iter;

  logic [TIME_W-1:0] span;
  logic              clear;
  logic [CW-1:0]     eff;
  logic [SW-1:0]     slot_next;
  logic [CW-1:0]     count_inc;
  logic [CW-1:0]     cm1;
  logic [OW-1:0]     newest_x;
  logic [OW-1:0]     cm1_x;
  logic [OW-1:0]     oldest_x;
  logic [SW-1:0]     raddr;
  logic [DVD_W:0]    shifted;
  logic [DVD_W:0]    diff;
  logic              fits;
  logic              multi;
  logic              zero_span;
  logic [BPM_W-1:0]  t_high;
  logic [BPM_W-1:0]  t_clamp;

  assign span      = now - rdata;
  assign clear     = (count != '0) && (span > TIME_W'(reset_gap_ms));
  assign eff       = clear ? '0 : count;
  assign slot_next = (eff == '0 || newest == SW'(WINDOW_TAPS - 1)) ? '0 : newest + 1'b1;
  assign count_inc = (eff < CW'(WINDOW_TAPS)) ? eff + 1'b1 : eff;
  assign cm1       = count - 1'b1;
  assign newest_x  = OW'(newest);
  assign cm1_x     = OW'(cm1);
  assign oldest_x  = (newest_x >= cm1_x) ? newest_x - cm1_x
                                         : newest_x + OW'(WINDOW_TAPS) - cm1_x;
  assign raddr     = cmd.rd_new ? newest : oldest_x[SW-1:0];
  assign multi     = count >= CW'(2);
  assign zero_span = span == '0;

  assign shifted = {rem, dq[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  assign t_high  = (dq > DVD_W'(tempo_high)) ? tempo_high : dq[BPM_W-1:0];
  assign t_clamp = (t_high < tempo_low) ? tempo_low : t_high;

  assign status.skip     = !multi || zero_span;
  assign status.div_done = iter == IW'(DVD_W - 1);
  assign status.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      store[slot_next] <= now;
    end
    if (cmd.rd_new || cmd.rd_old) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      newest <= '0;
      iter   <= '0;
    end else begin
      if (cmd.upd) begin
        count  <= count_inc;
        newest <= slot_next;
      end
      if (cmd.start) begin
        iter <= '0;
      end else if (cmd.step) begin
        iter <= iter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now <= tap_time_ms;
    end
    if (cmd.rd_old) begin
      num_q <= NUM_W'(MS_PER_MIN) * NUM_W'(cm1);
    end
    if (cmd.start) begin
      rem <= '0;
      dvs <= DVD_W'({span, 1'b0});
      if (zero_span) begin
        dq <= DVD_W'(tempo_high);
      end else begin
        dq <= DVD_W'({num_q, 1'b0}) + DVD_W'(span);
      end
    end else if (cmd.step) begin
      rem <= fits ? diff[DVD_W-1:0] : shifted[DVD_W-1:0];
      dq  <= {dq[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish && status.out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && status.out_free) begin
      tempo_valid <= multi;
      tempo_bpm   <= multi ? t_clamp : '0;
      taps_held   <= count;
    end
  end

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |=> count != '0)
    else $error("tap window empty after a tap was stored");

  a_single_tap: assert property (@(posedge clk) disable iff (rst)
    res_valid && !tempo_valid |-> tempo_bpm == '0 && taps_held == CW'(1))
    else $error("result without a tempo must hold exactly one tap");

  a_load_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd.finish))
    else $error("result register loaded outside the finish step");

endmodule

/* src/tap_tempo_estimator_top.sv */
// Top level of the tap tempo estimator: configuration registers on the APB-style port,
// and the controller and datapath. Depends on tte_pkg, tte_ctrl and tte_dp.
//
// Usage: each transaction on the tap channel (tap_valid, tap_stall, tap_time_ms) carries
// one tap with its millisecond timestamp. For each tap exactly one transaction leaves on
// the result channel (res_valid, res_stall, tempo_valid, tempo_bpm, taps_held).
// The tap is held in an eight-entry window by default; a gap above reset_gap_ms restarts
// the window. With two or more taps the tempo is rounded and clamped to the limits.
// A tap that starts or restarts the window or whose window spans no time skips the
// restoring divider, which otherwise retires one quotient bit per cycle. One tap is
// processed at a time, so a tap is taken only once the last one is through.
// tap_stall is low only while the block is idle. The result sits in an output register;
// a stalled result holds, and the next tap is taken and worked on meanwhile, waiting
// at its end until the register is free.
// Reset clears the window, drops any pending result and sets the registers to
// reset_gap_ms 2000, tempo_low 20 and tempo_high 300.
module tap_tempo_estimator_top #(
  parameter int unsigned WINDOW_TAPS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tte_pkg::ADDR_W-1:0]       paddr,
  input  logic [tte_pkg::CFG_W-1:0]        pwdata,
  output logic [tte_pkg::CFG_W-1:0]        prdata,
  output logic                             pready,
  input  logic                             tap_valid,
  output logic                             tap_stall,
  input  logic [tte_pkg::TIME_W-1:0]       tap_time_ms,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic                             tempo_valid,
  output logic [tte_pkg::BPM_W-1:0]        tempo_bpm,
  output logic [$clog2(WINDOW_TAPS+1)-1:0] taps_held
);
  import tte_pkg::*;

  logic [GAP_W-1:0] reset_gap_ms;
  logic [BPM_W-1:0] tempo_low;
  logic [BPM_W-1:0] tempo_high;
  logic             wr_en;
  logic [1:0]       reg_idx;
  tte_cmd_t         cmd;
  tte_stat_t        status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_gap_ms <= RESET_GAP_INIT;
      tempo_low    <= TEMPO_LOW_INIT;
      tempo_high   <= TEMPO_HIGH_INIT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RESET_GAP:  reset_gap_ms <= pwdata[GAP_W-1:0];
        REG_TEMPO_LOW:  tempo_low    <= pwdata[BPM_W-1:0];
        REG_TEMPO_HIGH: tempo_high   <= pwdata[BPM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RESET_GAP:  prdata = CFG_W'(reset_gap_ms);
      REG_TEMPO_LOW:  prdata = CFG_W'(tempo_low);
      REG_TEMPO_HIGH: prdata = CFG_W'(tempo_high);
      default:        prdata = '0;
    endcase
  end

  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .tap_stall (tap_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tte_dp #(
    .WINDOW_TAPS (WINDOW_TAPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .tap_time_ms  (tap_time_ms),
    .reset_gap_ms (reset_gap_ms),
    .tempo_low    (tempo_low),
    .tempo_high   (tempo_high),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .tempo_valid  (tempo_valid),
    .tempo_bpm    (tempo_bpm),
    .taps_held    (taps_held)
  );

endmodule

/* dv/tap_tempo_estimator_top_tb.sv */
// Self-checking testbench for tap_tempo_estimator_top: directed taps and register writes from
// a table, then random taps under random register settings, with an internal tempo predictor.
// Depends on tte_pkg and tap_tempo_estimator_top.
`timescale 1ns / 100ps

module tap_tempo_estimator_top_tb;
  import tte_pkg::*;

  localparam int unsigned WINDOW = 8;
  localparam int unsigned HELD_W = $clog2(WINDOW + 1);
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned TAPS_PER_PHASE = 150;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [BPM_W-1:0]  bpm;
    logic [HELD_W-1:0] held;
  } tempo_result_t;

  typedef enum logic {ROW_TAP, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        reg_idx;
    logic [31:0]       value;
    logic              fixed;
    logic              valid;
    logic [BPM_W-1:0]  bpm;
    logic [HELD_W-1:0] held;
  } dir_row_t;

  localparam dir_row_t DIRECTED [34] = '{
    '{ROW_TAP, REG_RESET_GAP, 32'd0,          1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_TAP, REG_RESET_GAP, 32'd500,        1'b1, 1'b1, 10'd120,  4'd2},
    '{ROW_TAP, REG_RESET_GAP, 32'd500,        1'b1, 1'b1, 10'd240,  4'd3},
    '{ROW_TAP, REG_RESET_GAP, 32'd5000,       1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_TAP, REG_RESET_GAP, 32'd5000,       1'b1, 1'b1, 10'd300,  4'd2},
    '{ROW_TAP, REG_RESET_GAP, 32'd5001,       1'b1, 1'b1, 10'd300,  4'd3},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_0000,  1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_07D0,  1'b1, 1'b1, 10'd30,   4'd2},
    '{ROW_TAP, REG_RESET_GAP, 32'h7FFF_FFFF,  1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_TAP, REG_RESET_GAP, 32'hFFFF_FF00,  1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_0100,  1'b1, 1'b1, 10'd117,  4'd2},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_0290,  1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_0420,  1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_05B0,  1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_0740,  1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_08D0,  1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_0A60,  1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_0BF0,  1'b1, 1'b1, 10'd150,  4'd8},
    '{ROW_TAP, REG_RESET_GAP, 32'h0000_0D80,  1'b1, 1'b1, 10'd150,  4'd8},
    '{ROW_REG, REG_RESET_GAP, 32'd0,          1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_REG, REG_TEMPO_LOW, 32'd1000,       1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_REG, REG_TEMPO_HIGH, 32'd1,         1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_REG, REG_UNUSED,    32'hFFFF_FFFF,  1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'd7,          1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_TAP, REG_RESET_GAP, 32'd7,          1'b1, 1'b1, 10'd1000, 4'd2},
    '{ROW_TAP, REG_RESET_GAP, 32'd8,          1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_REG, REG_RESET_GAP, 32'd65535,      1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_REG, REG_TEMPO_LOW, 32'd1,          1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_REG, REG_TEMPO_HIGH, 32'd1000,      1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'd0,          1'b1, 1'b0, 10'd0,    4'd1},
    '{ROW_TAP, REG_RESET_GAP, 32'd60,         1'b1, 1'b1, 10'd1000, 4'd2},
    '{ROW_TAP, REG_RESET_GAP, 32'd65595,      1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'd131130,     1'b0, 1'b0, 10'd0,    4'd0},
    '{ROW_TAP, REG_RESET_GAP, 32'd131130,     1'b0, 1'b0, 10'd0,    4'd0}
  };

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [CFG_W-1:0]     pwdata;
  logic [CFG_W-1:0]     prdata;
  logic                 pready;
  logic                 tap_valid;
  logic                 tap_stall;
  logic [TIME_W-1:0]    tap_time_ms;
  logic                 res_valid;
  logic                 res_stall;
  logic                 tempo_valid;
  logic [BPM_W-1:0]     tempo_bpm;
  logic [HELD_W-1:0]    taps_held;

  // Predictor state.
  logic [TIME_W-1:0]    tap_hist [WINDOW];
  int unsigned          held_cnt;
  int unsigned          newest;
  logic [GAP_W-1:0]     gap_reg;
  logic [BPM_W-1:0]     low_reg;
  logic [BPM_W-1:0]     high_reg;

  tempo_result_t        expected_tempos [$];
  int unsigned          error_count;
  int unsigned          taps_sent;
  int unsigned          results_seen;
  int unsigned          settings_used;
  int unsigned          quiet_cycles;
  bit                   sender_idle;
  bit                   stall_on;
  int unsigned          stall_left;

  tap_tempo_estimator_top #(
    .WINDOW_TAPS(WINDOW)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .tap_valid(tap_valid),
    .tap_stall(tap_stall),
    .tap_time_ms(tap_time_ms),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .tempo_valid(tempo_valid),
    .tempo_bpm(tempo_bpm),
    .taps_held(taps_held)
  );

  always #10 clk = ~clk;

  function automatic tempo_result_t tempo_for_tap(input logic [TIME_W-1:0] now);
    tempo_result_t r;
    logic [TIME_W-1:0] since_last;
    logic [TIME_W-1:0] span;
    logic [63:0] num;
    logic [63:0] bpm;
    int unsigned oldest;
    r = '0;
    since_last = now - tap_hist[newest];
    if (held_cnt > 0 && since_last > TIME_W'(gap_reg)) begin
      held_cnt = 0;
    end
    newest = (held_cnt == 0) ? 0 : (newest + 1) % WINDOW;
    tap_hist[newest] = now;
    if (held_cnt < WINDOW) begin
      held_cnt++;
    end
    if (held_cnt >= 2) begin
      oldest = (newest + WINDOW - (held_cnt - 1)) % WINDOW;
      span = now - tap_hist[oldest];
      if (span == 0) begin
        bpm = 64'(high_reg);
      end else begin
        num = 64'(MS_PER_MIN) * 64'(held_cnt - 1);
        bpm = (2 * num + 64'(span)) / (2 * 64'(span));
      end
      if (bpm > 64'(high_reg)) begin
        bpm = 64'(high_reg);
      end
      if (bpm < 64'(low_reg)) begin
        bpm = 64'(low_reg);
      end
      r.valid = 1'b1;
      r.bpm = bpm[BPM_W-1:0];
    end
    r.held = HELD_W'(held_cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    tempo_result_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_tempos.size() == 0) begin
        error_count++;
        $error("unexpected result: tempo_valid %0d tempo_bpm %0d taps_held %0d",
               tempo_valid, tempo_bpm, taps_held);
      end else begin
        want = expected_tempos.pop_front();
        check_field("tempo_valid", 32'(want.valid), 32'(tempo_valid));
        check_field("tempo_bpm", 32'(want.bpm), 32'(tempo_bpm));
        check_field("taps_held", 32'(want.held), 32'(taps_held));
      end
    end
  end

  // Result back-pressure in random bursts.
  always @(negedge clk) begin
    if (rst || !stall_on) begin
      stall_left = 0;
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (tap_valid && !tap_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_access(input logic wr, input logic [1:0] idx, input logic [31:0] data,
                            output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] rd;
    logic [31:0] want;
    cfg_access(1'b1, idx, data, rd);
    case (idx)
      REG_RESET_GAP: begin
        gap_reg = data[GAP_W-1:0];
        want = 32'(gap_reg);
      end
      REG_TEMPO_LOW: begin
        low_reg = data[BPM_W-1:0];
        want = 32'(low_reg);
      end
      REG_TEMPO_HIGH: begin
        high_reg = data[BPM_W-1:0];
        want = 32'(high_reg);
      end
      default: begin
        want = '0;
      end
    endcase
    if (idx != REG_UNUSED) begin
      cfg_access(1'b0, idx, '0, rd);
      check_field("register readback", want, rd);
    end
  endtask

  task automatic send_tap(input logic [TIME_W-1:0] t, input logic fixed, input tempo_result_t want);
    tempo_result_t predicted;
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      tap_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    tap_valid <= 1'b1;
    tap_time_ms <= t;
    do @(posedge clk); while (tap_stall);
    predicted = tempo_for_tap(t);
    expected_tempos.insert(expected_tempos.size(), fixed ? want : predicted);
    taps_sent++;
  endtask

  // Stops the tap stream and waits for every outstanding result.
  task automatic drain;
    @(negedge clk);
    tap_valid <= 1'b0;
    while (expected_tempos.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [TIME_W-1:0] now;
    logic [31:0] data;
    logic [GAP_W-1:0] gap_pick;
    logic [BPM_W-1:0] low_pick;
    logic [BPM_W-1:0] high_pick;
    int unsigned pick;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tap_valid = 1'b0;
    tap_time_ms = '0;
    res_stall = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      tap_hist[i] = '0;
    end
    held_cnt = 0;
    newest = 0;
    gap_reg = RESET_GAP_INIT;
    low_reg = TEMPO_LOW_INIT;
    high_reg = TEMPO_HIGH_INIT;
    error_count = 0;
    taps_sent = 0;
    results_seen = 0;
    settings_used = 1;
    sender_idle = 1'b1;
    stall_on = 1'b1;
    stall_left = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        drain();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
        settings_used++;
      end else begin
        send_tap(DIRECTED[i].value, DIRECTED[i].fixed,
                 '{DIRECTED[i].valid, DIRECTED[i].bpm, DIRECTED[i].held});
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case ($urandom_range(0, 5))
        0: gap_pick = '0;
        1: gap_pick = '1;
        2: gap_pick = GAP_W'($urandom_range(0, 65535));
        default: gap_pick = GAP_W'($urandom_range(300, 3000));
      endcase
      case ($urandom_range(0, 4))
        0: begin
          low_pick = BPM_W'($urandom_range(0, 1023));
          high_pick = BPM_W'($urandom_range(0, 1023));
        end
        1: begin
          low_pick = 10'd1;
          high_pick = 10'd1000;
        end
        2: begin
          low_pick = '1;
          high_pick = '0;
        end
        default: begin
          low_pick = BPM_W'($urandom_range(1, 60));
          high_pick = BPM_W'($urandom_range(200, 1023));
        end
      endcase
      data = $urandom();
      data[GAP_W-1:0] = gap_pick;
      write_reg(REG_RESET_GAP, data);
      data = $urandom();
      data[BPM_W-1:0] = low_pick;
      write_reg(REG_TEMPO_LOW, data);
      data = $urandom();
      data[BPM_W-1:0] = high_pick;
      write_reg(REG_TEMPO_HIGH, data);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, $urandom());
      end
      settings_used++;

      sender_idle = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stall_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      now = ($urandom_range(0, 1) == 0) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 20000);

      for (int k = 0; k < TAPS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          if (gap_reg > 3000 && $urandom_range(0, 1) == 0) begin
            now = now + $urandom_range(0, 3000);
          end else begin
            now = now + $urandom_range(0, gap_reg);
          end
        end else if (pick < 78) begin
          now = now + gap_reg + 1 + $urandom_range(0, 5000);
        end else if (pick < 84) begin
          now = now;
        end else if (pick < 88) begin
          now = now + gap_reg;
        end else if (pick < 92) begin
          now = now - $urandom_range(1, 1000);
        end else begin
          now = $urandom();
        end
        send_tap(now, 1'b0, '0);
        if ($urandom_range(0, 199) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("Checked %0d results from %0d taps over %0d register settings,", results_seen,
             taps_sent, settings_used);
    $display("including wrapping time, zero span, window restarts and crossed tempo limits.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
